// ===== rtl/core/qmm_pkg.sv =====
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared types, register map and constants for the quad motor mixer.
// ----------------------------------------------------------------------------
package qmm_pkg;

  localparam int PULSE_W   = 12;
  localparam int IDLE_W    = 10;
  localparam int STICK_W   = 16;
  localparam int TERM_W    = 12;
  localparam int ACC_W     = 18;
  localparam int MOTORS    = 4;
  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [PULSE_W-1:0] PULSE_MIN_RST   = 12'd1100;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST   = 12'd1900;
  localparam logic [IDLE_W-1:0]  IDLE_OFFSET_RST = 10'd130;

  localparam logic signed [STICK_W-1:0] TEST_THRESH     = 16'sd3000;
  localparam logic signed [STICK_W-1:0] TEST_THRESH_NEG = -16'sd3000;
  localparam logic [PULSE_W-1:0]        TEST_STEP       = 12'd100;
  localparam logic [TERM_W+7:0]         SCALE_NUM       = 20'd181;
  localparam logic [TERM_W+7:0]         SCALE_ROUND     = 20'd255;
  localparam int                        SCALE_SHIFT     = 8;
  localparam logic signed [ACC_W-1:0]   OUT_TOP         = 18'sd4095;

  localparam logic [REG_IDX_W-1:0] REG_PULSE_MIN   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PULSE_MAX   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IDLE_OFFSET = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_X_FRAME     = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CUT_ENABLE  = 3'd4;

  typedef enum logic [1:0] {
    KIND_ARMED    = 2'd0,
    KIND_DISARMED = 2'd1,
    KIND_TEST     = 2'd2
  } qmm_kind_t;

  typedef logic signed [ACC_W-1:0] qmm_acc_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
    logic [IDLE_W-1:0]  idle_offset;
    logic               x_frame;
    logic               cut_enable;
  } qmm_cfg_t;

  // laid out to match the stream data word, last field lowest
  typedef struct packed {
    logic [STICK_W-1:0] pitch_stick;
    logic [STICK_W-1:0] roll_stick;
    logic [STICK_W-1:0] throttle_stick;
    logic [TERM_W-1:0]  yaw_term;
    logic [TERM_W-1:0]  pitch_term;
    logic [TERM_W-1:0]  roll_term;
    logic [PULSE_W-1:0] throttle_pulse;
    logic [STICK_W-1:0] throttle_command;
  } qmm_item_t;

  // multiply by 181/256, truncated toward zero
  function automatic logic signed [TERM_W-1:0] scale_707(input logic signed [TERM_W-1:0] v);
    logic signed [TERM_W+7:0] p;
    p = {{8{v[TERM_W-1]}}, v} * SCALE_NUM;
    if (p[TERM_W+7]) begin
      p = p + SCALE_ROUND;
    end
    return TERM_W'(p >>> SCALE_SHIFT);
  endfunction

endpackage

// ===== rtl/core/qmm_mix.sv =====
// ----------------------------------------------------------------------------
// qmm_mix
// Frame mix, yaw, clip with pair transfer, floor/cut and saturation; test steps; auto-arm.
// ----------------------------------------------------------------------------
module qmm_mix import qmm_pkg::*; (
  input  qmm_kind_t                         kind,
  input  qmm_item_t                         item,
  input  qmm_cfg_t                          cfg,
  input  logic                              armed_flag,
  output logic [MOTORS-1:0][PULSE_W-1:0]    motor,
  output logic                              armed_flag_next
);

  logic signed [TERM_W-1:0]  roll;
  logic signed [TERM_W-1:0]  pitch;
  logic signed [TERM_W-1:0]  r_s;
  logic signed [TERM_W-1:0]  p_s;
  logic signed [STICK_W-1:0] thr_cmd;
  logic signed [STICK_W-1:0] thr_stick;
  logic signed [STICK_W-1:0] rs;
  logic signed [STICK_W-1:0] ps;
  logic                      thr_pos;
  qmm_acc_t                  base;
  qmm_acc_t                  rr;
  qmm_acc_t                  pp;
  qmm_acc_t                  yaw;
  qmm_acc_t                  mx;
  qmm_acc_t                  mn;
  qmm_acc_t                  pmin;
  qmm_acc_t                  step;
  qmm_acc_t                  m [MOTORS];

  assign roll      = item.roll_term;
  assign pitch     = item.pitch_term;
  assign thr_cmd   = item.throttle_command;
  assign thr_stick = item.throttle_stick;
  assign rs        = item.roll_stick;
  assign ps        = item.pitch_stick;
  assign r_s       = scale_707(roll);
  assign p_s       = scale_707(pitch);
  assign thr_pos   = thr_cmd > 16'sd0;

  always_comb begin
    base = qmm_acc_t'({6'd0, item.throttle_pulse});
    yaw  = qmm_acc_t'($signed(item.yaw_term));
    mx   = qmm_acc_t'({6'd0, cfg.pulse_max});
    pmin = qmm_acc_t'({6'd0, cfg.pulse_min});
    step = qmm_acc_t'({6'd0, TEST_STEP});
    mn   = pmin;
    if (thr_pos) begin
      mn = pmin + qmm_acc_t'({8'd0, cfg.idle_offset});
    end
    armed_flag_next = armed_flag;
    rr = '0;
    pp = '0;
    for (int i = 0; i < MOTORS; i++) begin
      m[i] = pmin;
    end

    case (kind)
      KIND_ARMED: begin
        if (cfg.x_frame) begin
          rr   = qmm_acc_t'(r_s);
          pp   = qmm_acc_t'(p_s);
          m[2] = base + rr + pp;
          m[1] = base + rr - pp;
          m[0] = base - rr + pp;
          m[3] = base - rr - pp;
        end else begin
          rr   = qmm_acc_t'(roll);
          pp   = qmm_acc_t'(pitch);
          m[0] = base - rr;
          m[1] = base + rr;
          m[2] = base + pp;
          m[3] = base - pp;
        end
        m[0] = m[0] + yaw;
        m[1] = m[1] + yaw;
        m[2] = m[2] - yaw;
        m[3] = m[3] - yaw;
        // clip in order, excess goes off the paired motor
        for (int i = 0; i < MOTORS; i++) begin
          if (m[i] > mx) begin
            m[i ^ 1] = m[i ^ 1] - (m[i] - mx);
            m[i]     = mx;
          end
        end
        for (int i = 0; i < MOTORS; i++) begin
          if (m[i] < mn) begin
            m[i] = mn;
          end
        end
        if (cfg.cut_enable && !thr_pos) begin
          for (int i = 0; i < MOTORS; i++) begin
            m[i] = pmin;
          end
        end
      end
      KIND_TEST: begin
        if (cfg.x_frame) begin
          if (rs > TEST_THRESH) begin
            m[0] = m[0] + step;
            m[3] = m[3] + step;
          end
          if (rs < TEST_THRESH_NEG) begin
            m[1] = m[1] + step;
            m[2] = m[2] + step;
          end
          if (ps > TEST_THRESH) begin
            m[1] = m[1] + step;
            m[3] = m[3] + step;
          end
          if (ps < TEST_THRESH_NEG) begin
            m[0] = m[0] + step;
            m[2] = m[2] + step;
          end
        end else begin
          if (rs > TEST_THRESH) m[0] = m[0] + step;
          if (rs < TEST_THRESH_NEG) m[1] = m[1] + step;
          if (ps > TEST_THRESH) m[3] = m[3] + step;
          if (ps < TEST_THRESH_NEG) m[2] = m[2] + step;
        end
      end
      default: begin
        // disarmed and unused kind
        if (thr_stick > 16'sd0) begin
          armed_flag_next = 1'b1;
        end
      end
    endcase

    for (int i = 0; i < MOTORS; i++) begin
      if (m[i] < 18'sd0) begin
        motor[i] = '0;
      end else if (m[i] > OUT_TOP) begin
        motor[i] = '1;
      end else begin
        motor[i] = m[i][PULSE_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/quad_motor_mixer.sv =====
// path: an input transfer goes to the input register, then through the single-pass mix
//   to the result register, before the earliest output transfer; m_tready low stalls it
// throughput: one item per cycle while the output is not stalled by m_tready
// reset: rst clears both valid flags, the auto-armed flag and loads the
//   register defaults; no item is lost across the pipeline while stalled
// ----------------------------------------------------------------------------
// quad_motor_mixer
// Quad motor mixer with stream ports and a register port.
// ----------------------------------------------------------------------------
module quad_motor_mixer import qmm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // throttle_command, throttle_pulse, roll_term, pitch_term, yaw_term,
  // throttle_stick, roll_stick, pitch_stick
  input  logic [111:0]        s_tdata,
  // kind
  input  logic [1:0]          s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // motor_a, motor_b, motor_c, motor_d, auto_armed, zero pad
  output logic [55:0]         m_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  qmm_cfg_t                         cfg;
  logic [REG_IDX_W-1:0]             reg_idx;
  logic                             cfg_wr;
  logic                             in_valid;
  qmm_item_t                        in_item;
  qmm_kind_t                        in_kind;
  logic                             out_valid;
  logic [MOTORS-1:0][PULSE_W-1:0]   out_motor;
  logic                             out_armed;
  logic                             armed_flag;
  logic                             armed_flag_next;
  logic [MOTORS-1:0][PULSE_W-1:0]   motor_next;
  logic                             out_adv;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_min   <= PULSE_MIN_RST;
      cfg.pulse_max   <= PULSE_MAX_RST;
      cfg.idle_offset <= IDLE_OFFSET_RST;
      cfg.x_frame     <= 1'b1;
      cfg.cut_enable  <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_PULSE_MIN:   cfg.pulse_min   <= pwdata[PULSE_W-1:0];
        REG_PULSE_MAX:   cfg.pulse_max   <= pwdata[PULSE_W-1:0];
        REG_IDLE_OFFSET: cfg.idle_offset <= pwdata[IDLE_W-1:0];
        REG_X_FRAME:     cfg.x_frame     <= pwdata[0];
        REG_CUT_ENABLE:  cfg.cut_enable  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PULSE_MIN:   prdata = {20'd0, cfg.pulse_min};
      REG_PULSE_MAX:   prdata = {20'd0, cfg.pulse_max};
      REG_IDLE_OFFSET: prdata = {22'd0, cfg.idle_offset};
      REG_X_FRAME:     prdata = {31'd0, cfg.x_frame};
      REG_CUT_ENABLE:  prdata = {31'd0, cfg.cut_enable};
      default:         prdata = '0;
    endcase
  end

  assign out_adv  = !out_valid || m_tready;
  assign s_tready = !in_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item <= qmm_item_t'(s_tdata);
      in_kind <= qmm_kind_t'(s_tuser);
    end
  end

  qmm_mix u_mix (
    .kind            (in_kind),
    .item            (in_item),
    .cfg             (cfg),
    .armed_flag      (armed_flag),
    .motor           (motor_next),
    .armed_flag_next (armed_flag_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      armed_flag <= 1'b0;
    end else if (out_adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        armed_flag <= armed_flag_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_valid) begin
      out_motor <= motor_next;
      out_armed <= armed_flag_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_armed, out_motor};

endmodule

// ===== rtl/core/qmm_checker.sv =====
// ----------------------------------------------------------------------------
// qmm_checker
// Port-level checks for the quad motor mixer, bound to the top level.
// ----------------------------------------------------------------------------
module qmm_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output back-pressure");

  a_armed_sticky: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tdata[48] |=> !m_tvalid || m_tdata[48])
    else $error("auto-armed flag cleared");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind quad_motor_mixer qmm_checker u_qmm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/quad_motor_mixer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_motor_mixer_tb
// Self-checking bench for the quad motor mixer. Items go in over the input
// stream and a scoreboard class predicts the four motor pulses and the
// auto-armed flag for each accepted transfer, then compares every output
// transfer against the oldest prediction. A directed set of corner items
// runs first, then random items across several register settings, with
// random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module quad_motor_mixer_tb import qmm_pkg::*;;

  localparam logic [1:0] KIND_SPARE   = 2'd3;
  localparam int         THROTTLE_TOP = 1000;
  localparam int         X_SCALE_NUM  = 181;
  localparam int         X_SCALE_DEN  = 256;
  localparam int         PULSE_TOP    = 4095;
  localparam int         PHASES       = 8;
  localparam int         PHASE_ITEMS  = 225;
  localparam int         HOLD_AT      = 300;
  localparam int         HOLD_CYCLES  = 150;
  localparam int         IDLE_LIMIT   = 4000;

  typedef struct packed {
    logic [6:0]         pad;
    logic               auto_armed;
    logic [PULSE_W-1:0] motor_d;
    logic [PULSE_W-1:0] motor_c;
    logic [PULSE_W-1:0] motor_b;
    logic [PULSE_W-1:0] motor_a;
  } motor_word_t;

  class mixer_scoreboard;
    qmm_cfg_t    cfg;
    bit          armed_flag;
    motor_word_t expected_pulses[$];
    int          errors;

    function new();
      cfg.pulse_min   = PULSE_MIN_RST;
      cfg.pulse_max   = PULSE_MAX_RST;
      cfg.idle_offset = IDLE_OFFSET_RST;
      cfg.x_frame     = 1'b1;
      cfg.cut_enable  = 1'b1;
      armed_flag      = 1'b0;
      errors          = 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        REG_PULSE_MIN:   cfg.pulse_min   = v[PULSE_W-1:0];
        REG_PULSE_MAX:   cfg.pulse_max   = v[PULSE_W-1:0];
        REG_IDLE_OFFSET: cfg.idle_offset = v[IDLE_W-1:0];
        REG_X_FRAME:     cfg.x_frame     = v[0];
        REG_CUT_ENABLE:  cfg.cut_enable  = v[0];
        default: ;
      endcase
    endfunction

    function int clip_pulse(int v);
      if (v < 0) return 0;
      if (v > PULSE_TOP) return PULSE_TOP;
      return v;
    endfunction

    function motor_word_t mix_motors(qmm_item_t it, logic [1:0] k);
      int m[4];
      int thr, base, roll, pitch, yaw, r, p, lo, hi, rs, ps;
      motor_word_t w;
      w = '0;
      for (int i = 0; i < 4; i++) m[i] = int'(cfg.pulse_min);
      case (k)
        KIND_ARMED: begin
          thr   = int'($signed(it.throttle_command));
          base  = int'(it.throttle_pulse);
          roll  = int'($signed(it.roll_term));
          pitch = int'($signed(it.pitch_term));
          yaw   = int'($signed(it.yaw_term));
          if (thr < 0) thr = 0;
          if (thr > THROTTLE_TOP) thr = THROTTLE_TOP;
          lo = int'(cfg.pulse_min);
          if (thr > 0) lo = int'(cfg.pulse_min) + int'(cfg.idle_offset);
          hi = int'(cfg.pulse_max);
          if (cfg.x_frame) begin
            r = (roll * X_SCALE_NUM) / X_SCALE_DEN;
            p = (pitch * X_SCALE_NUM) / X_SCALE_DEN;
            m[2] = base + r + p;
            m[1] = base + r - p;
            m[0] = base - r + p;
            m[3] = base - r - p;
          end else begin
            m[0] = base - roll;
            m[1] = base + roll;
            m[2] = base + pitch;
            m[3] = base - pitch;
          end
          m[0] += yaw;
          m[1] += yaw;
          m[2] -= yaw;
          m[3] -= yaw;
          // clip in order, excess comes off the paired motor
          for (int i = 0; i < 4; i++) begin
            if (m[i] > hi) begin
              m[i ^ 1] -= m[i] - hi;
              m[i] = hi;
            end
          end
          for (int i = 0; i < 4; i++) begin
            if (m[i] < lo) m[i] = lo;
          end
          if (cfg.cut_enable && thr == 0) begin
            for (int i = 0; i < 4; i++) m[i] = int'(cfg.pulse_min);
          end
        end
        KIND_TEST: begin
          rs = int'($signed(it.roll_stick));
          ps = int'($signed(it.pitch_stick));
          if (cfg.x_frame) begin
            if (rs > TEST_THRESH) begin
              m[0] += int'(TEST_STEP);
              m[3] += int'(TEST_STEP);
            end
            if (rs < TEST_THRESH_NEG) begin
              m[1] += int'(TEST_STEP);
              m[2] += int'(TEST_STEP);
            end
            if (ps > TEST_THRESH) begin
              m[1] += int'(TEST_STEP);
              m[3] += int'(TEST_STEP);
            end
            if (ps < TEST_THRESH_NEG) begin
              m[0] += int'(TEST_STEP);
              m[2] += int'(TEST_STEP);
            end
          end else begin
            if (rs > TEST_THRESH) m[0] += int'(TEST_STEP);
            if (rs < TEST_THRESH_NEG) m[1] += int'(TEST_STEP);
            if (ps > TEST_THRESH) m[3] += int'(TEST_STEP);
            if (ps < TEST_THRESH_NEG) m[2] += int'(TEST_STEP);
          end
        end
        default: begin
          // disarmed and the spare kind
          if ($signed(it.throttle_stick) > 0) armed_flag = 1'b1;
        end
      endcase
      w.motor_a    = PULSE_W'(clip_pulse(m[0]));
      w.motor_b    = PULSE_W'(clip_pulse(m[1]));
      w.motor_c    = PULSE_W'(clip_pulse(m[2]));
      w.motor_d    = PULSE_W'(clip_pulse(m[3]));
      w.auto_armed = armed_flag;
      return w;
    endfunction

    function void note_item(qmm_item_t it, logic [1:0] k);
      expected_pulses.push_back(mix_motors(it, k));
    endfunction

    function void compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_pulses(logic [55:0] data);
      motor_word_t got, want;
      got = data;
      if (expected_pulses.size() == 0) begin
        $error("output transfer with no item pending: %h", data);
        errors++;
        return;
      end
      want = expected_pulses.pop_front();
      compare_field("motor_a", want.motor_a, got.motor_a);
      compare_field("motor_b", want.motor_b, got.motor_b);
      compare_field("motor_c", want.motor_c, got.motor_c);
      compare_field("motor_d", want.motor_d, got.motor_d);
      compare_field("auto_armed", want.auto_armed, got.auto_armed);
    endfunction

    function int pending();
      return expected_pulses.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  // throttle_command, throttle_pulse, roll_term, pitch_term, yaw_term,
  // throttle_stick, roll_stick, pitch_stick
  logic [111:0]       s_tdata = '0;
  // kind
  logic [1:0]         s_tuser = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  // motor_a, motor_b, motor_c, motor_d, auto_armed, zero pad
  logic [55:0]        m_tdata;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [ADDR_W-1:0]  paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  mixer_scoreboard sb = new();
  bit              steady_sender = 1'b0;

  quad_motor_mixer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic int rand_stick();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2, 3: return int'($urandom_range(0, 65535)) - 32768;
      4: return ($urandom_range(0, 1) ? 3000 : -3000) + int'($urandom_range(0, 2)) - 1;
      default: return int'($urandom_range(0, 8000)) - 4000;
    endcase
  endfunction

  function automatic int rand_term();
    case ($urandom_range(0, 9))
      0: return -2048;
      1: return 2047;
      2, 3, 4, 5: return int'($urandom_range(0, 4095)) - 2048;
      default: return int'($urandom_range(0, 800)) - 400;
    endcase
  endfunction

  function automatic int rand_throttle();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return int'($urandom_range(0, 65535)) - 32768;
      2: return 999 + int'($urandom_range(0, 2));
      default: return int'($urandom_range(0, 1100)) - 50;
    endcase
  endfunction

  function automatic int rand_pulse();
    if ($urandom_range(0, 9) < 3) return $urandom_range(0, 4095);
    return $urandom_range(900, 2100);
  endfunction

  task automatic drive_item(input logic [1:0] k, input int tc, tp, rl, pt, yw, ts, rs, ps);
    qmm_item_t it;
    int gap;
    it.throttle_command = 16'(tc);
    it.throttle_pulse   = 12'(tp);
    it.roll_term        = 12'(rl);
    it.pitch_term       = 12'(pt);
    it.yaw_term         = 12'(yw);
    it.throttle_stick   = 16'(ts);
    it.roll_stick       = 16'(rs);
    it.pitch_stick      = 16'(ps);
    gap = steady_sender ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it;
    s_tuser  <= k;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(it, k);
  endtask

  task automatic send_random();
    int r;
    logic [1:0] k;
    r = $urandom_range(0, 99);
    if (r < 60) k = KIND_ARMED;
    else if (r < 75) k = KIND_DISARMED;
    else if (r < 90) k = KIND_TEST;
    else k = KIND_SPARE;
    drive_item(k, rand_throttle(), rand_pulse(), rand_term(), rand_term(), rand_term(),
               rand_stick(), rand_stick(), rand_stick());
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // waits for the pipeline to drain, then loads a full register set
  task automatic program_mixer(input int pmin, pmax, idle, input bit xf, cut);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    reg_write(REG_PULSE_MIN, 32'(pmin));
    reg_write(REG_PULSE_MAX, 32'(pmax));
    reg_write(REG_IDLE_OFFSET, 32'(idle));
    reg_write(REG_X_FRAME, 32'(xf));
    reg_write(REG_CUT_ENABLE, 32'(cut));
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_pulses(m_tdata);
  end

  always @(posedge clk) begin : watchdog
    int idle_cycles;
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // output side: random stalls, calm stretches and one long hold
  initial begin : sink
    int stall_left;
    int cyc;
    int seen;
    bit held;
    stall_left = 0;
    cyc = 0;
    seen = 0;
    held = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (m_tvalid && m_tready) seen++;
      if (!held && seen == HOLD_AT) begin
        held = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!cyc[8]) stall_left = pick_stall();
      end
      cyc++;
      @(posedge clk);
    end
  end

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed corners under reset defaults
    drive_item(KIND_DISARMED, 0, 0, 0, 0, 0, 0, 0, 0);
    drive_item(KIND_DISARMED, 0, 0, 0, 0, 0, -32768, 0, 0);
    drive_item(KIND_ARMED, 500, 1500, 100, -50, 20, 0, 0, 0);
    drive_item(KIND_TEST, 0, 0, 0, 0, 0, 0, 3001, -3001);
    drive_item(KIND_SPARE, 0, 0, 0, 0, 0, 1, 0, 0);
    drive_item(KIND_DISARMED, 0, 0, 0, 0, 0, 32767, 0, 0);
    drive_item(KIND_ARMED, -32768, 1500, 10, 10, 10, 0, 0, 0);
    drive_item(KIND_ARMED, 32767, 4095, 2047, 2047, 2047, 0, 0, 0);
    drive_item(KIND_ARMED, 1, 0, -2048, -2048, -2048, 0, 0, 0);
    drive_item(KIND_ARMED, 0, 1500, 300, -300, 50, 0, 0, 0);
    drive_item(KIND_ARMED, 1000, 1800, -1, 1, 0, 0, 0, 0);
    drive_item(KIND_ARMED, 1001, 1880, -300, 0, 100, 0, 0, 0);
    drive_item(KIND_ARMED, 999, 1700, 255, -255, -1, 0, 0, 0);
    drive_item(KIND_ARMED, 500, 1500, -181, 181, -2048, 0, 0, 0);
    drive_item(KIND_TEST, 0, 0, 0, 0, 0, 0, 3000, -3000);
    drive_item(KIND_TEST, 0, 0, 0, 0, 0, 0, -3001, 3001);
    drive_item(KIND_TEST, 0, 0, 0, 0, 0, 0, 32767, 32767);
    drive_item(KIND_TEST, 0, 0, 0, 0, 0, 0, -32768, -32768);
    drive_item(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, 0);
    drive_item(KIND_SPARE, 0, 0, 0, 0, 0, -1, 0, 0);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: program_mixer($urandom_range(900, 1200), $urandom_range(1700, 2100),
                         $urandom_range(0, 200), 1'b1, 1'b1);
        1: program_mixer($urandom_range(900, 1200), $urandom_range(1700, 2100),
                         $urandom_range(0, 200), 1'b0, 1'b0);
        2: program_mixer(0, 4095, 0, 1'b1, 1'b0);
        3: program_mixer(4095, 0, 1023, 1'b0, 1'b1);
        5: program_mixer(1000, 2000, 1023, 1'b0, 1'b1);
        7: program_mixer($urandom_range(900, 1200), $urandom_range(1700, 2100),
                         $urandom_range(0, 200), 1'b1, 1'b0);
        default: program_mixer($urandom_range(0, 4095), $urandom_range(0, 4095),
                               $urandom_range(0, 1023), $urandom_range(0, 1),
                               $urandom_range(0, 1));
      endcase
      steady_sender = (ph % 3 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) send_random();
    end

    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
